// ----- rtl/core/olir_pkg.sv -----
// Package for the ordered list block: sizes, operation and status codes,
// beat layouts and the command passed along the chain of list cells.
// No dependencies.
package olir_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;
    localparam int WORD_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND    = 3'd0,
        FN_PUSH_HEAD = 3'd1,
        FN_POP_HEAD  = 3'd2,
        FN_POP_TAIL  = 3'd3,
        FN_REMOVE_AT = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_AT,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [IDX_W-1:0]      sel;
        logic [IDX_W-1:0]      tap;
        logic [DATA_W-1:0]     item;
    } t_cell_cmd;

    // last field in the lowest bits
    typedef struct packed {
        logic                  pad;
        logic [POS_W-1:0]      position;
        logic [WORD_W-1:0]     item;
        logic [FUNC_W-1:0]     func;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0]     tail_item;
        logic [WORD_W-1:0]     head_item;
        logic                  is_empty;
        logic [COUNT_W-1:0]    count;
        logic [STAT_W-1:0]     status;
        logic [WORD_W-1:0]     removed_item;
    } t_out_beat;

    localparam int IN_TDATA_W  = $bits(t_in_beat);
    localparam int OUT_TDATA_W = $bits(t_out_beat);

endpackage

// ----- rtl/core/ordered_list_with_indexed_removal_top.sv -----
// Bounded ordered list of up to 16 words held in a row of shifting cells.
// Each input beat carries one operation (append, insert at head, remove
// head, remove tail, remove at position); each gives exactly one output
// beat with the removed word, status, count, empty flag, head and tail.
// An operation passes through S_IDLE, which captures the beat, S_EXEC, in
// which the cells shift or load under one command, and S_REPORT, which
// writes the output register, with head and tail, once it is free. A new
// beat is taken while a finished one still waits. Errors leave the list as is.
// Depends on olir_pkg, olir_cell and olir_ctrl.
module ordered_list_with_indexed_removal_top
    import olir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // func[2:0], item[34:3], position[38:35], zero[39]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // removed_item[31:0], status[33:32], count[38:34], is_empty[39],
    // head_item[71:40], tail_item[103:72]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_cell_cmd          w_cmd;
    t_out_beat          w_out;
    logic [DATA_W-1:0]  w_data [DEPTH];
    logic [DATA_W-1:0]  w_tap  [DEPTH];
    logic [DATA_W-1:0]  w_tap_or;

    olir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_in_beat  (t_in_beat'(i_s_tdata)),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_out_beat (w_out),
        .o_cmd      (w_cmd),
        .i_tap      (w_tap_or),
        .i_head     (w_data[0])
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = w_cmd.item;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end

        olir_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(k)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tap_or = w_tap_or | w_tap[k];
        end
    end

    assign o_m_tdata = OUT_TDATA_W'(w_out);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_out.count <= COUNT_W'(DEPTH)))
        else $error("count beyond depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_out.is_empty == (w_out.count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_out.is_empty) |->
            (w_out.head_item == '0 && w_out.tail_item == '0))
        else $error("head or tail not zero on empty list");

    a_error_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_out.status != STAT_OK) |-> (w_out.removed_item == '0))
        else $error("removed word on failed operation");
`endif

endmodule

// ----- rtl/core/olir_cell.sv -----
// One list cell: holds the entry at a fixed list position and takes a new
// word from the command, its left or its right neighbour.
// Depends on olir_pkg.
module olir_cell
    import olir_pkg::*;
(
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_idx,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_tap
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            CELL_LOAD_AT: begin
                if (i_idx == i_cmd.sel) begin
                    n_data = i_cmd.item;
                end
            end
            CELL_SHIFT_IN: begin
                n_data = i_left;
            end
            CELL_SHIFT_OUT: begin
                if (i_idx >= i_cmd.sel) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_idx == i_cmd.tap) ? r_data : '0;

endmodule

// ----- rtl/core/olir_ctrl.sv -----
// Sequencer for the ordered list: takes input beats, keeps the count,
// drives the cell chain and holds the output beat register.
// Depends on olir_pkg.
module olir_ctrl
    import olir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  t_in_beat               i_in_beat,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output t_out_beat              o_out_beat,
    output t_cell_cmd              o_cmd,
    input  logic [DATA_W-1:0]      i_tap,
    input  logic [DATA_W-1:0]      i_head
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_func              r_func, n_func;
    logic [DATA_W-1:0]  r_item, n_item;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_removed, n_removed;
    t_out_beat          r_out, n_out;

    logic               w_empty;
    logic [IDX_W-1:0]   w_last;

    assign w_empty = (r_count == '0);
    assign w_last  = IDX_W'(r_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_item    <= n_item;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_item      = r_item;
        n_pos       = r_pos;
        n_status    = r_status;
        n_removed   = r_removed;
        n_out       = r_out;
        o_cmd.op    = CELL_HOLD;
        o_cmd.sel   = '0;
        o_cmd.tap   = '0;
        o_cmd.item  = r_item;
        o_s_tready  = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_func  = t_func'(i_in_beat.func);
                    n_item  = DATA_W'(i_in_beat.item);
                    n_pos   = i_in_beat.position;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = STAT_OK;
                n_removed = '0;
                case (r_func)
                    FN_APPEND, FN_PUSH_HEAD: begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_cmd.op  = (r_func == FN_APPEND) ? CELL_LOAD_AT : CELL_SHIFT_IN;
                            o_cmd.sel = IDX_W'(r_count);
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    FN_POP_HEAD, FN_POP_TAIL: begin
                        if (w_empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            o_cmd.op  = CELL_SHIFT_OUT;
                            o_cmd.sel = (r_func == FN_POP_HEAD) ? '0 : w_last;
                            o_cmd.tap = o_cmd.sel;
                            n_removed = i_tap;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    FN_REMOVE_AT: begin
                        if (CNT_W'(r_pos) >= r_count) begin
                            n_status = STAT_RANGE;
                        end else begin
                            o_cmd.op  = CELL_SHIFT_OUT;
                            o_cmd.sel = IDX_W'(r_pos);
                            o_cmd.tap = o_cmd.sel;
                            n_removed = i_tap;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
                n_state = S_REPORT;
            end
            S_REPORT: begin
                o_cmd.tap = w_last;
                if (!r_out_valid || i_m_tready) begin
                    n_out.removed_item = WORD_W'(r_removed);
                    n_out.status       = r_status;
                    n_out.count        = COUNT_W'(r_count);
                    n_out.is_empty     = w_empty;
                    n_out.head_item    = w_empty ? '0 : WORD_W'(i_head);
                    n_out.tail_item    = w_empty ? '0 : WORD_W'(i_tap);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_out_beat = r_out;

endmodule

// ----- tb/sv/olir_list_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the ordered list block: watches both stream channels, predicts
// every output beat from the accepted input beats and compares field by field.
// Depends on olir_pkg.
module olir_list_checker
    import olir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // func[2:0], item[34:3], position[38:35], zero[39]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // removed_item[31:0], status[33:32], count[38:34], is_empty[39],
    // head_item[71:40], tail_item[103:72]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic [DATA_W-1:0] list_words[$];
    t_out_beat         awaited_beats[$];
    int                fail_count    = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        fail_count++;
        if (fail_count <= 40) begin
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    function automatic t_out_beat apply_list_op(input t_in_beat beat);
        t_out_beat res;
        res        = '0;
        res.status = STAT_OK;
        case (beat.func)
            FN_APPEND, FN_PUSH_HEAD: begin
                if (list_words.size() >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (beat.func == FN_APPEND) begin
                    list_words.push_back(beat.item);
                end else begin
                    list_words.push_front(beat.item);
                end
            end
            FN_POP_HEAD, FN_POP_TAIL: begin
                if (list_words.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else if (beat.func == FN_POP_HEAD) begin
                    res.removed_item = list_words.pop_front();
                end else begin
                    res.removed_item = list_words.pop_back();
                end
            end
            FN_REMOVE_AT: begin
                if (beat.position >= list_words.size()) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.removed_item = list_words[beat.position];
                    list_words.delete(beat.position);
                end
            end
            default: begin
            end
        endcase
        res.count    = COUNT_W'(list_words.size());
        res.is_empty = (list_words.size() == 0);
        if (list_words.size() != 0) begin
            res.head_item = list_words[0];
            res.tail_item = list_words[$];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            list_words.delete();
            awaited_beats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (awaited_beats.size() == 0) begin
                    report_mismatch("unexpected beat", got.removed_item, '0);
                end else begin
                    want = awaited_beats.pop_front();
                    if (got.removed_item !== want.removed_item)
                        report_mismatch("removed_item", got.removed_item, want.removed_item);
                    if (got.status !== want.status)
                        report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("count", WORD_W'(got.count), WORD_W'(want.count));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", WORD_W'(got.is_empty),
                                        WORD_W'(want.is_empty));
                    if (got.head_item !== want.head_item)
                        report_mismatch("head_item", got.head_item, want.head_item);
                    if (got.tail_item !== want.tail_item)
                        report_mismatch("tail_item", got.tail_item, want.tail_item);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_beats.push_back(apply_list_op(i_s_tdata));
            end
        end
        pending_count = awaited_beats.size();
    end

endmodule

// ----- tb/sv/ordered_list_with_indexed_removal_top_test.sv -----
`timescale 1ns / 1ps
// Test top for the ordered list block: clock, reset, directed and random
// operation beats with bursty sending and a stalling receiver, and the verdict.
// Depends on olir_pkg, ordered_list_with_indexed_removal_top and olir_list_checker.
module ordered_list_with_indexed_removal_top_test;
    import olir_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_C = 3'd7;

    localparam int RANDOM_OPS = 1450;
    localparam int HOLD_OFF   = 300;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    int                     fail_count;
    int                     pending;
    int                     burst_left = 0;

    ordered_list_with_indexed_removal_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    olir_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // between bursts, usually drop valid for a random gap, then offer one beat until taken
    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word,
                           input logic [POS_W-1:0] pos);
        t_in_beat beat;
        beat          = '0;
        beat.func     = func;
        beat.item     = word;
        beat.position = pos;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tdata  = beat;
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    initial begin : receiver
        int seg;
        int stall_pct;
        seg = 0;
        wait (i_rst_n);
        forever begin
            seg++;
            if (seg % 16 == 5) begin
                @(negedge i_clk);
                i_m_tready = 1'b0;
                repeat (HOLD_OFF) @(negedge i_clk);
            end else begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
                repeat ($urandom_range(20, 150)) begin
                    @(negedge i_clk);
                    i_m_tready = ($urandom_range(0, 99) >= stall_pct);
                end
            end
        end
    end

    initial begin : stimulus
        int                mode;
        int                mode_left;
        int                push_pct;
        int                pick;
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // errors on an empty list and the spare codes
        send_op(FN_POP_HEAD, '0, '0);
        send_op(FN_POP_TAIL, '1, '1);
        send_op(FN_REMOVE_AT, '0, '0);
        send_op(FN_UNUSED_A, 32'h1234_5678, 4'd3);
        send_op(FN_UNUSED_B, '1, '1);
        send_op(FN_UNUSED_C, '0, '0);

        // fill to the brim from both ends, then push once more at each end
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0)      word = '0;
            else if (k == 1) word = '1;
            else             word = $urandom();
            send_op(k[0] ? FN_PUSH_HEAD : FN_APPEND, word, '0);
        end
        send_op(FN_APPEND, 32'h5A5A_5A5A, '0);
        send_op(FN_PUSH_HEAD, 32'hA5A5_A5A5, '0);

        // take out the tail, the head and a middle entry by position
        send_op(FN_REMOVE_AT, '0, 4'd15);
        send_op(FN_REMOVE_AT, '0, 4'd0);
        send_op(FN_REMOVE_AT, '0, 4'd7);

        mode      = MODE_MIX;
        mode_left = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(MODE_FILL, MODE_MIX);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                MODE_FILL:  push_pct = 70;
                MODE_DRAIN: push_pct = 20;
                default:    push_pct = 45;
            endcase

            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3) begin
                func = FUNC_W'($urandom_range(FN_UNUSED_A, FN_UNUSED_C));
            end else if (pick < push_pct) begin
                func = $urandom_range(0, 1) ? FN_APPEND : FN_PUSH_HEAD;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 3)      func = FN_POP_HEAD;
                else if (pick < 6) func = FN_POP_TAIL;
                else               func = FN_REMOVE_AT;
            end

            case ($urandom_range(0, 19))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom();
            endcase
            pos = ($urandom_range(0, 9) < 6) ? POS_W'($urandom_range(0, 5))
                                             : POS_W'($urandom_range(0, 15));

            send_op(func, word, pos);
        end

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- ordered_list_with_indexed_removal_top.f -----
rtl/core/olir_pkg.sv
rtl/core/olir_cell.sv
rtl/core/olir_ctrl.sv
rtl/core/ordered_list_with_indexed_removal_top.sv
tb/sv/olir_list_checker.sv
tb/sv/ordered_list_with_indexed_removal_top_test.sv
